// ===== rtl/pcrd_pkg.sv =====
// pcrd_pkg: shared types and constants of the pinhole camera ray generator
// holds the input and result word structs and the register index codes
// no dependencies
package pcrd_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int FRAC_W     = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [15:0] HEADING_X_RST = 16'sd16384;
  localparam logic signed [15:0] HEADING_Y_RST = 16'sd0;
  localparam logic [12:0]        VIEW_W_RST    = 13'd640;
  localparam logic [12:0]        VIEW_H_RST    = 13'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADING_X = 3'd0,
    REG_HEADING_Y = 3'd1,
    REG_POS_X     = 3'd2,
    REG_POS_Y     = 3'd3,
    REG_POS_Z     = 3'd4,
    REG_VIEW_W    = 3'd5,
    REG_VIEW_H    = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [11:0] pixel_col;
    logic [11:0] pixel_row;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
  } out_word_t;

  typedef struct packed {
    logic [2:0]  neg;
    logic [30:0] mag_x;
    logic [30:0] mag_y;
    logic [30:0] mag_z;
  } side_t;

endpackage

// ===== rtl/pixel_camera_ray_direction_top.sv =====
// pixel_camera_ray_direction_top: pinhole camera ray generator
// depends on pcrd_pkg and pcrd_div
//
// usage: one pixel word (column, row) in on in_valid/in_ready, one ray word
// out on out_valid/out_ready carrying the unit direction in Q2.14 and the
// camera position in Q16.16 as origin.
// throughput is one word per cycle unless out_ready stalls the pipeline. the
// depth is set by the 15 stage scale dividers, the 32 stage integer square
// root and the 15 stage normalizing dividers, one bit each.
// columns and rows past the view size clamp to the last column or row.
// the config port writes one register per cycle with cfg_we; it must only
// be written while no word is in flight.
// reset empties the pipeline and loads heading (1,0), position zero and a
// 640 by 480 view.
// when out_ready is low with a word waiting, the whole pipeline holds and
// in_ready drops in the same cycle; nothing is lost or repeated.
module pixel_camera_ray_direction_top
  import pcrd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DIV_Q_W  = 15;
  localparam int SQRT_N   = 32;
  localparam int LAT      = 1 + DIV_Q_W + 4 + SQRT_N + 1 + DIV_Q_W + 1;
  localparam int HNUM_W   = 27;
  localparam int FNUM_W   = 46;

  logic signed [15:0] heading_x_r, heading_y_r;
  logic signed [31:0] pos_x_r, pos_y_r, pos_z_r;
  logic [12:0]        view_w_r, view_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heading_x_r <= HEADING_X_RST;
      heading_y_r <= HEADING_Y_RST;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      pos_z_r     <= '0;
      view_w_r    <= VIEW_W_RST;
      view_h_r    <= VIEW_H_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEADING_X: heading_x_r <= cfg_data[15:0];
        REG_HEADING_Y: heading_y_r <= cfg_data[15:0];
        REG_POS_X:     pos_x_r     <= cfg_data;
        REG_POS_Y:     pos_y_r     <= cfg_data;
        REG_POS_Z:     pos_z_r     <= cfg_data;
        REG_VIEW_W:    view_w_r    <= cfg_data[12:0];
        REG_VIEW_H:    view_h_r    <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic [LAT-1:0] vld_r;

  assign en       = !vld_r[LAT-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // clamp and scale numerators
  logic [12:0] w_c, h_c, col13, row13, col_c, row_c;
  logic [14:0] hd, vd, hmag15, vmag15;
  logic [HNUM_W-1:0] hnum, vnum;

  always_comb begin
    w_c = view_w_r;
    if (view_w_r == 13'd0) w_c = 13'd1;
    else if (view_w_r > 13'(MAX_DIM)) w_c = 13'(MAX_DIM);
    h_c = view_h_r;
    if (view_h_r == 13'd0) h_c = 13'd1;
    else if (view_h_r > 13'(MAX_DIM)) h_c = 13'(MAX_DIM);
    col13 = {1'b0, in_data.pixel_col};
    row13 = {1'b0, in_data.pixel_row};
    col_c = (col13 > w_c - 13'd1) ? w_c - 13'd1 : col13;
    row_c = (row13 > h_c - 13'd1) ? h_c - 13'd1 : row13;
    hd     = {1'b0, col_c, 1'b0} - {2'b00, w_c};
    vd     = {2'b00, h_c} - {1'b0, row_c, 1'b0};
    hmag15 = hd[14] ? (~hd + 15'd1) : hd;
    vmag15 = vd[14] ? (~vd + 15'd1) : vd;
    hnum   = {hmag15[12:0], {FRAC_W{1'b0}}} + HNUM_W'(w_c[12:1]);
    vnum   = {vmag15[12:0], {FRAC_W{1'b0}}} + HNUM_W'(h_c[12:1]);
  end

  logic [HNUM_W-1:0] a_hnum_r, a_vnum_r;
  logic [12:0]       a_hden_r, a_vden_r;
  logic [1:0]        a_neg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a_hnum_r <= hnum;
      a_vnum_r <= vnum;
      a_hden_r <= w_c;
      a_vden_r <= h_c;
      a_neg_r  <= {hd[14], vd[14]};
    end
  end

  logic [DIV_Q_W-1:0] hq, vq;
  logic [1:0] sneg_r [DIV_Q_W];

  pcrd_div #(.NUM_W(HNUM_W), .DEN_W(13), .Q_W(DIV_Q_W)) u_hdiv (
    .clk(clk), .en(en), .num_i(a_hnum_r), .den_i(a_hden_r), .q_o(hq)
  );
  pcrd_div #(.NUM_W(HNUM_W), .DEN_W(13), .Q_W(DIV_Q_W)) u_vdiv (
    .clk(clk), .en(en), .num_i(a_vnum_r), .den_i(a_vden_r), .q_o(vq)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sneg_r[0] <= a_neg_r;
      for (int i = 1; i < DIV_Q_W; i++) sneg_r[i] <= sneg_r[i-1];
    end
  end

  // products with the heading
  logic signed [15:0] hsq, vsq;
  logic signed [31:0] m_p1_r, m_p2_r;
  logic signed [15:0] m_vsq_r;

  assign hsq = sneg_r[DIV_Q_W-1][1] ? -$signed({1'b0, hq}) : $signed({1'b0, hq});
  assign vsq = sneg_r[DIV_Q_W-1][0] ? -$signed({1'b0, vq}) : $signed({1'b0, vq});

  always_ff @(posedge clk) begin
    if (en) begin
      m_p1_r  <= heading_y_r * hsq;
      m_p2_r  <= heading_x_r * hsq;
      m_vsq_r <= vsq;
    end
  end

  // direction sums, split into sign and magnitude
  logic signed [32:0] dx, dy, dz;
  logic [32:0] ax, ay, az;
  side_t d_side_r, q_side_r, s_side_r;

  always_comb begin
    dx = $signed({{3{heading_x_r[15]}}, heading_x_r, {FRAC_W{1'b0}}})
         + $signed({m_p1_r[31], m_p1_r});
    dy = $signed({{3{heading_y_r[15]}}, heading_y_r, {FRAC_W{1'b0}}})
         - $signed({m_p2_r[31], m_p2_r});
    dz = $signed({{3{m_vsq_r[15]}}, m_vsq_r, {FRAC_W{1'b0}}});
    ax = dx[32] ? -dx : dx;
    ay = dy[32] ? -dy : dy;
    az = dz[32] ? -dz : dz;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_side_r <= '{neg: {dx[32], dy[32], dz[32]},
                    mag_x: ax[30:0], mag_y: ay[30:0], mag_z: az[30:0]};
    end
  end

  logic [61:0] q_sx_r, q_sy_r, q_sz_r;
  logic [63:0] s_sum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      q_sx_r   <= d_side_r.mag_x * d_side_r.mag_x;
      q_sy_r   <= d_side_r.mag_y * d_side_r.mag_y;
      q_sz_r   <= d_side_r.mag_z * d_side_r.mag_z;
      q_side_r <= d_side_r;
      s_sum_r  <= 64'(q_sx_r) + 64'(q_sy_r) + 64'(q_sz_r);
      s_side_r <= q_side_r;
    end
  end

  // integer square root, one result bit per stage
  logic [63:0] sq_s_r [SQRT_N];
  logic [63:0] sq_r_r [SQRT_N];
  side_t       sq_side_r [SQRT_N];

  for (genvar i = 0; i < SQRT_N; i++) begin : g_sqrt
    logic [63:0] s_in, r_in, bitv, trial;
    side_t       side_in;

    if (i == 0) begin : g_first
      assign s_in    = s_sum_r;
      assign r_in    = '0;
      assign side_in = s_side_r;
    end else begin : g_next
      assign s_in    = sq_s_r[i-1];
      assign r_in    = sq_r_r[i-1];
      assign side_in = sq_side_r[i-1];
    end

    assign bitv  = 64'd1 << (2 * (SQRT_N - 1 - i));
    assign trial = r_in + bitv;

    always_ff @(posedge clk) begin
      if (en) begin
        if (s_in >= trial) begin
          sq_s_r[i] <= s_in - trial;
          sq_r_r[i] <= (r_in >> 1) + bitv;
        end else begin
          sq_s_r[i] <= s_in;
          sq_r_r[i] <= r_in >> 1;
        end
        sq_side_r[i] <= side_in;
      end
    end
  end

  // normalize
  logic [31:0]       n;
  side_t             nside;
  logic [FNUM_W-1:0] f_num_x_r, f_num_y_r, f_num_z_r;
  logic [31:0]       f_den_r;
  logic [3:0]        f_flag_r;

  assign n     = sq_r_r[SQRT_N-1][31:0];
  assign nside = sq_side_r[SQRT_N-1];

  always_ff @(posedge clk) begin
    if (en) begin
      f_num_x_r <= FNUM_W'({nside.mag_x, {FRAC_W{1'b0}}}) + FNUM_W'(n[31:1]);
      f_num_y_r <= FNUM_W'({nside.mag_y, {FRAC_W{1'b0}}}) + FNUM_W'(n[31:1]);
      f_num_z_r <= FNUM_W'({nside.mag_z, {FRAC_W{1'b0}}}) + FNUM_W'(n[31:1]);
      f_den_r   <= n;
      f_flag_r  <= {n == 32'd0, nside.neg};
    end
  end

  logic [DIV_Q_W-1:0] ux, uy, uz;
  logic [3:0] fflag_r [DIV_Q_W];

  pcrd_div #(.NUM_W(FNUM_W), .DEN_W(32), .Q_W(DIV_Q_W)) u_xdiv (
    .clk(clk), .en(en), .num_i(f_num_x_r), .den_i(f_den_r), .q_o(ux)
  );
  pcrd_div #(.NUM_W(FNUM_W), .DEN_W(32), .Q_W(DIV_Q_W)) u_ydiv (
    .clk(clk), .en(en), .num_i(f_num_y_r), .den_i(f_den_r), .q_o(uy)
  );
  pcrd_div #(.NUM_W(FNUM_W), .DEN_W(32), .Q_W(DIV_Q_W)) u_zdiv (
    .clk(clk), .en(en), .num_i(f_num_z_r), .den_i(f_den_r), .q_o(uz)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      fflag_r[0] <= f_flag_r;
      for (int i = 1; i < DIV_Q_W; i++) fflag_r[i] <= fflag_r[i-1];
    end
  end

  logic [3:0] oflag;
  logic signed [15:0] o_x_r, o_y_r, o_z_r;

  assign oflag = fflag_r[DIV_Q_W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      o_x_r <= oflag[3] ? '0 : (oflag[2] ? -$signed({1'b0, ux}) : $signed({1'b0, ux}));
      o_y_r <= oflag[3] ? '0 : (oflag[1] ? -$signed({1'b0, uy}) : $signed({1'b0, uy}));
      o_z_r <= oflag[3] ? '0 : (oflag[0] ? -$signed({1'b0, uz}) : $signed({1'b0, uz}));
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign out_data  = '{dir_x: o_x_r, dir_y: o_y_r, dir_z: o_z_r,
                       origin_x: pos_x_r, origin_y: pos_y_r, origin_z: pos_z_r};

endmodule

// ===== rtl/pcrd_div.sv =====
// pcrd_div: pipelined restoring divider, one quotient bit per stage
// the quotient must be known to fit in Q_W bits; depends on nothing
module pcrd_div #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 13,
  parameter int Q_W   = 15
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   q_o
);

  localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [CW-1:0]    rem_r [Q_W-1];
  logic [DEN_W-1:0] den_r [Q_W-1];
  logic [Q_W-1:0]   q_r   [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_step
    logic [CW-1:0]    rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   q_in;
    logic [CW-1:0]    dsh;
    logic             ge;

    if (j == 0) begin : g_first
      assign rem_in = CW'(num_i);
      assign den_in = den_i;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign q_in   = q_r[j-1];
    end

    assign dsh = CW'(den_in) << (Q_W - 1 - j);
    assign ge  = rem_in >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[j] <= q_in | (ge ? (Q_W'(1) << (Q_W - 1 - j)) : '0);
      end
    end

    if (j < Q_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= ge ? rem_in - dsh : rem_in;
          den_r[j] <= den_in;
        end
      end
    end
  end

  assign q_o = q_r[Q_W-1];

endmodule

// ===== rtl/pcrd_checker.sv =====
// pcrd_checker: port level checks of the ray generator, bound to the top
// depends on pcrd_pkg
module pcrd_checker
  import pcrd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.dir_x >= -16384 && out_data.dir_x <= 16384 &&
                  out_data.dir_y >= -16384 && out_data.dir_y <= 16384 &&
                  out_data.dir_z >= -16384 && out_data.dir_z <= 16384)
    else $error("direction component out of range");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind pixel_camera_ray_direction_top pcrd_checker u_pcrd_checker (.*);

// ===== sim/testbench.sv =====
// testbench: randomized check of the pinhole camera ray generator
// drives pixel words, predicts each ray word in a scoreboard class and compares
// depends on pcrd_pkg and pixel_camera_ray_direction_top
`timescale 1ns / 100ps

module testbench;
  import pcrd_pkg::*;

  localparam int LATENCY = 69;
  localparam int CYCLE_LIMIT = 600000;

  class ray_scoreboard;
    logic signed [15:0] hx, hy;
    logic [31:0] px, py, pz;
    logic [12:0] vw, vh;
    out_word_t pending[$];
    int errors;
    int mismatches;

    function void reset_regs();
      hx = HEADING_X_RST;
      hy = HEADING_Y_RST;
      px = 0;
      py = 0;
      pz = 0;
      vw = VIEW_W_RST;
      vh = VIEW_H_RST;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [31:0] val);
      case (idx)
        REG_HEADING_X: hx = val[15:0];
        REG_HEADING_Y: hy = val[15:0];
        REG_POS_X: px = val;
        REG_POS_Y: py = val;
        REG_POS_Z: pz = val;
        REG_VIEW_W: vw = val[12:0];
        REG_VIEW_H: vh = val[12:0];
        default: ;
      endcase
    endfunction

    function longint round_div(longint num, longint den);
      longint mag;
      longint q;
      mag = num < 0 ? -num : num;
      q = (mag + den / 2) / den;
      return num < 0 ? -q : q;
    endfunction

    function longint int_sqrt(logic [63:0] s);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
        if (s >= r + b) begin
          s = s - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return longint'(r);
    endfunction

    function logic [15:0] to_unit(longint d, longint n);
      longint q;
      if (n == 0) return 16'd0;
      q = round_div(d * 16384, n);
      if (q > 16384) q = 16384;
      if (q < -16384) q = -16384;
      return q[15:0];
    endfunction

    function longint clamp_size(logic [12:0] v);
      longint d;
      d = v;
      if (d < 1) d = 1;
      if (d > MAX_DIM) d = MAX_DIM;
      return d;
    endfunction

    function void note_pixel(in_word_t w);
      longint wd, ht, col, row, hsq, vsq, dx, dy, dz, n;
      logic [63:0] ax, ay, az;
      out_word_t r;
      wd = clamp_size(vw);
      ht = clamp_size(vh);
      col = w.pixel_col;
      row = w.pixel_row;
      if (col > wd - 1) col = wd - 1;
      if (row > ht - 1) row = ht - 1;
      hsq = round_div((2 * col - wd) * 16384, wd);
      vsq = round_div((ht - 2 * row) * 16384, ht);
      dx = longint'(hx) * 16384 + longint'(hy) * hsq;
      dy = longint'(hy) * 16384 - longint'(hx) * hsq;
      dz = vsq * 16384;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      az = dz < 0 ? -dz : dz;
      n = int_sqrt(ax * ax + ay * ay + az * az);
      r.dir_x = to_unit(dx, n);
      r.dir_y = to_unit(dy, n);
      r.dir_z = to_unit(dz, n);
      r.origin_x = px;
      r.origin_y = py;
      r.origin_z = pz;
      pending.push_back(r);
    endfunction

    function void check_ray(out_word_t got);
      out_word_t e;
      if (pending.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected ray word %h", got);
        return;
      end
      e = pending.pop_front();
      if (got.dir_x !== e.dir_x || got.dir_y !== e.dir_y || got.dir_z !== e.dir_z ||
          got.origin_x !== e.origin_x || got.origin_y !== e.origin_y ||
          got.origin_z !== e.origin_z) begin
        errors++;
        if (mismatches++ < 10)
          $display("mismatch dir exp %0d %0d %0d got %0d %0d %0d org exp %h %h %h got %h %h %h",
                   e.dir_x, e.dir_y, e.dir_z, got.dir_x, got.dir_y, got.dir_z,
                   e.origin_x, e.origin_y, e.origin_z,
                   got.origin_x, got.origin_y, got.origin_z);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ray_scoreboard rays = new();
  int cycles = 0;
  bit calm = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pixel_camera_ray_direction_top dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: random stall bursts, none once calm
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) rays.check_ray(out_data);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 9);
        repeat (gap) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    rays.write_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(logic [11:0] col, logic [11:0] row);
    in_word_t w;
    w.pixel_col = col;
    w.pixel_row = row;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    rays.note_pixel(w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (rays.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [11:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return 12'($urandom_range(0, 15));
      1: return 12'hFFF;
      default: return 12'($urandom());
    endcase
  endfunction

  task automatic random_setup();
    logic [15:0] h;
    h = $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 32768) - 16384);
    write_reg(REG_HEADING_X, 32'(h));
    h = $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 32768) - 16384);
    write_reg(REG_HEADING_Y, 32'(h));
    write_reg(REG_POS_X, $urandom());
    write_reg(REG_POS_Y, $urandom());
    write_reg(REG_POS_Z, $urandom());
    case ($urandom_range(0, 4))
      0: write_reg(REG_VIEW_W, 32'(13'($urandom())));
      1: write_reg(REG_VIEW_W, $urandom_range(1, 8));
      default: write_reg(REG_VIEW_W, $urandom_range(1, 4096));
    endcase
    case ($urandom_range(0, 4))
      0: write_reg(REG_VIEW_H, 32'(13'($urandom())));
      1: write_reg(REG_VIEW_H, $urandom_range(1, 8));
      default: write_reg(REG_VIEW_H, $urandom_range(1, 4096));
    endcase
  endtask

  initial begin
    rays.reset_regs();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset view: corners, center, clamped pixels
    send_pixel(0, 0);
    send_pixel(639, 479);
    send_pixel(320, 240);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'hAAA, 12'h555);
    drain();

    // extremes: max size, min size, out of range size, odd headings
    write_reg(REG_HEADING_X, 32'h8000);
    write_reg(REG_HEADING_Y, 32'h7FFF);
    write_reg(REG_POS_X, 32'h8000_0000);
    write_reg(REG_POS_Y, 32'h7FFF_FFFF);
    write_reg(REG_POS_Z, 32'hFFFF_FFFF);
    write_reg(REG_VIEW_W, 32'd4096);
    write_reg(REG_VIEW_H, 32'd4096);
    send_pixel(0, 0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(2048, 2048);
    drain();
    write_reg(REG_VIEW_W, 32'd0);
    write_reg(REG_VIEW_H, 32'h1FFF);
    send_pixel(5, 4095);
    send_pixel(0, 2048);
    drain();
    // zero heading with row on the horizon gives a zero direction
    write_reg(REG_HEADING_X, 32'd0);
    write_reg(REG_HEADING_Y, 32'd0);
    write_reg(REG_VIEW_W, 32'd1);
    write_reg(REG_VIEW_H, 32'd2);
    send_pixel(0, 1);
    send_pixel(0, 0);
    drain();
    write_reg(REG_VIEW_H, 32'd1);
    send_pixel(0, 0);
    send_pixel(7, 9);
    drain();
    write_reg(REG_HEADING_X, 32'hC000);
    write_reg(REG_HEADING_Y, 32'd16384);
    write_reg(REG_VIEW_W, 32'd3);
    write_reg(REG_VIEW_H, 32'd5);
    for (int i = 0; i < 4; i++) send_pixel(12'(i), 12'(i + 1));
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      random_setup();
      if (phase == 11) calm = 1;
      for (int i = 0; i < 75; i++) send_pixel(pick_coord(), pick_coord());
      drain();
    end

    if (rays.errors == 0 && rays.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pcrd_pkg.sv
rtl/pcrd_div.sv
rtl/pixel_camera_ray_direction_top.sv
rtl/pcrd_checker.sv
sim/testbench.sv
